FILE: hw/rtl/encoded_word_text_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// Encoded-word decoder assertion macros
// Shared property shapes for the concurrent checks of the decoder core.
// ----------------------------------------------------------------------------
`ifndef ENCODED_WORD_TEXT_DECODER_CORE_DEFINES_SVH
`define ENCODED_WORD_TEXT_DECODER_CORE_DEFINES_SVH

// same-cycle implication, ignored while reset is high
`define EWD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked through reset
`define EWD_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ewd_pkg.sv
// ----------------------------------------------------------------------------
// Encoded-word decoder package
// Codes, constants and the item types passed between the decoder stages.
// ----------------------------------------------------------------------------
package ewd_pkg;

   localparam logic       ENC_B64     = 1'b0;
   localparam logic       ENC_Q       = 1'b1;

   localparam logic [1:0] CS_ASCII    = 2'd0;
   localparam logic [1:0] CS_UTF8     = 2'd1;
   localparam logic [1:0] CS_LATIN1   = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_MALFORMED = 2'd1;
   localparam logic [1:0] ST_INVALID   = 2'd2;
   localparam logic [1:0] ST_CAPACITY  = 2'd3;

   localparam logic       CSR_ENCODING = 1'b0;
   localparam logic       CSR_CHARSET  = 1'b1;

   localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CH_EQUALS     = 8'h3d;
   localparam logic [7:0] CH_SPACE      = 8'h20;

   localparam int MID_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   typedef enum logic [1:0] {
      EV_BYTE,
      EV_FAIL,
      EV_END
   } ev_kind_type;

   typedef struct packed {
      ev_kind_type kind;
      logic [7:0]  data;
      logic [1:0]  code;
   } mid_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_final;
      logic [1:0] status;
      logic [7:0] out_length;
   } rsp_item_type;

endpackage

FILE: hw/rtl/ewd_fifo.sv
// ----------------------------------------------------------------------------
// Encoded-word decoder queue
// Small first-in first-out store of registers with full and empty flags.
// ----------------------------------------------------------------------------
module ewd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNW-1:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: hw/rtl/ewd_front.sv
// ----------------------------------------------------------------------------
// Encoded-word decoder front end
// Accepts text characters, runs base64 or Q decoding and the decoded-byte
// capacity check, and queues byte, failure and end events in order.
// ----------------------------------------------------------------------------
module ewd_front import ewd_pkg::*; #(
   parameter int BUFFER_BYTES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         encoding_mode,
   input  logic         in_valid,
   input  logic [7:0]   in_byte,
   input  logic         in_end,
   output logic         in_ready,
   output mid_item_type mid_item,
   output logic         mid_push,
   input  logic         mid_full
);

   localparam int CW = $clog2(BUFFER_BYTES);

   localparam logic [1:0] Q_IDLE = 2'd0;
   localparam logic [1:0] Q_HIGH = 2'd1;
   localparam logic [1:0] Q_LOW  = 2'd2;

   logic [1:0]    pos_ff, pos_in;
   logic [23:0]   bits_ff, bits_in;
   logic [1:0]    pad_ff, pad_in;
   logic [1:0]    qph_ff, qph_in;
   logic [3:0]    hn_ff, hn_in;
   logic [CW-1:0] dcount_ff, dcount_in;
   logic          failed_ff, failed_in;
   logic [1:0]    pend_n_ff, pend_n_in;
   logic [23:0]   pend_data_ff, pend_data_in;
   logic          pend_fail_ff, pend_fail_in;
   logic          pend_end_ff, pend_end_in;
   logic          busy, accept;

   // {valid, value}
   function automatic logic [6:0] b64_decode(input logic [7:0] c);
      logic [6:0] r;
      r = '0;
      if (c >= 8'h41 && c <= 8'h5a) begin
         r = {1'b1, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         r = {1'b1, 6'(c - 8'h47)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 6'(c + 8'h04)};
      end else if (c == 8'h2b) begin
         r = {1'b1, 6'd62};
      end else if (c == 8'h2f) begin
         r = {1'b1, 6'd63};
      end
      return r;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

   assign busy     = (pend_n_ff != 2'd0) || pend_fail_ff || pend_end_ff;
   assign in_ready = !busy;
   assign accept   = in_valid && !busy;

   always_comb begin
      logic [6:0]  bv;
      logic [4:0]  hv;
      logic [1:0]  pad_next;
      logic [23:0] bits_next;
      logic        bad;

      pos_in       = pos_ff;
      bits_in      = bits_ff;
      pad_in       = pad_ff;
      qph_in       = qph_ff;
      hn_in        = hn_ff;
      dcount_in    = dcount_ff;
      failed_in    = failed_ff;
      pend_n_in    = pend_n_ff;
      pend_data_in = pend_data_ff;
      pend_fail_in = pend_fail_ff;
      pend_end_in  = pend_end_ff;
      mid_push     = 1'b0;
      mid_item     = '{kind: EV_BYTE, data: pend_data_ff[23:16], code: ST_OK};
      bv           = b64_decode(in_byte);
      hv           = hex_decode(in_byte);
      pad_next     = pad_ff;
      bits_next    = bits_ff;
      bad          = 1'b0;

      if (accept) begin
         if (in_end || in_byte == 8'h00) begin
            if (!failed_ff && ((encoding_mode == ENC_B64) ? (pos_ff != 2'd0)
                                                          : (qph_ff != Q_IDLE))) begin
               pend_fail_in = 1'b1;
               failed_in    = 1'b1;
            end
            pend_end_in = 1'b1;
         end else if (!failed_ff) begin
            if (encoding_mode == ENC_B64) begin
               if (pad_ff != 2'd0 && pos_ff == 2'd0) begin
                  bad = 1'b1;
               end else if (pos_ff[1] && in_byte == CH_EQUALS) begin
                  pad_next = pad_ff + 2'd1;
               end else if (!bv[6] || pad_ff != 2'd0) begin
                  bad = 1'b1;
               end else begin
                  unique case (pos_ff)
                     2'd0: bits_next = bits_ff | {bv[5:0], 18'd0};
                     2'd1: bits_next = bits_ff | {6'd0, bv[5:0], 12'd0};
                     2'd2: bits_next = bits_ff | {12'd0, bv[5:0], 6'd0};
                     2'd3: bits_next = bits_ff | {18'd0, bv[5:0]};
                  endcase
               end
               if (bad) begin
                  pend_fail_in = 1'b1;
                  failed_in    = 1'b1;
               end else begin
                  pad_in = pad_next;
                  if (pos_ff != 2'd3) begin
                     pos_in  = pos_ff + 2'd1;
                     bits_in = bits_next;
                  end else begin
                     pos_in       = 2'd0;
                     bits_in      = '0;
                     pend_n_in    = 2'd3 - pad_next;
                     pend_data_in = bits_next;
                  end
               end
            end else begin
               if (qph_ff == Q_IDLE) begin
                  if (in_byte == CH_UNDERSCORE) begin
                     pend_n_in    = 2'd1;
                     pend_data_in = {CH_SPACE, 16'd0};
                  end else if (in_byte == CH_EQUALS) begin
                     qph_in = Q_HIGH;
                  end else begin
                     pend_n_in    = 2'd1;
                     pend_data_in = {in_byte, 16'd0};
                  end
               end else if (!hv[4]) begin
                  pend_fail_in = 1'b1;
                  failed_in    = 1'b1;
               end else if (qph_ff == Q_HIGH) begin
                  hn_in  = hv[3:0];
                  qph_in = Q_LOW;
               end else begin
                  qph_in       = Q_IDLE;
                  pend_n_in    = 2'd1;
                  pend_data_in = {hn_ff, hv[3:0], 16'd0};
               end
            end
         end
      end else if (busy && !mid_full) begin
         mid_push = 1'b1;
         if (pend_n_ff != 2'd0) begin
            if (dcount_ff == CW'(BUFFER_BYTES - 1)) begin
               mid_item  = '{kind: EV_FAIL, data: 8'd0, code: ST_CAPACITY};
               failed_in = 1'b1;
               pend_n_in = 2'd0;
            end else begin
               dcount_in    = dcount_ff + CW'(1);
               pend_data_in = {pend_data_ff[15:0], 8'd0};
               pend_n_in    = pend_n_ff - 2'd1;
            end
         end else if (pend_fail_ff) begin
            mid_item     = '{kind: EV_FAIL, data: 8'd0, code: ST_MALFORMED};
            pend_fail_in = 1'b0;
         end else begin
            // close the word and start over
            mid_item    = '{kind: EV_END, data: 8'd0, code: ST_OK};
            pend_end_in = 1'b0;
            pos_in      = 2'd0;
            bits_in     = '0;
            pad_in      = 2'd0;
            qph_in      = Q_IDLE;
            hn_in       = 4'd0;
            dcount_in   = '0;
            failed_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 2'd0;
         bits_ff      <= '0;
         pad_ff       <= 2'd0;
         qph_ff       <= Q_IDLE;
         hn_ff        <= 4'd0;
         dcount_ff    <= '0;
         failed_ff    <= 1'b0;
         pend_n_ff    <= 2'd0;
         pend_fail_ff <= 1'b0;
         pend_end_ff  <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         bits_ff      <= bits_in;
         pad_ff       <= pad_in;
         qph_ff       <= qph_in;
         hn_ff        <= hn_in;
         dcount_ff    <= dcount_in;
         failed_ff    <= failed_in;
         pend_n_ff    <= pend_n_in;
         pend_fail_ff <= pend_fail_in;
         pend_end_ff  <= pend_end_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_data_ff <= pend_data_in;
   end

endmodule

FILE: hw/rtl/ewd_back.sv
// ----------------------------------------------------------------------------
// Encoded-word decoder back end
// Checks or converts decoded bytes for the character set, applies the output
// capacity limit and error priority, and builds the closing status item.
// ----------------------------------------------------------------------------
module ewd_back import ewd_pkg::*; #(
   parameter int BUFFER_BYTES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   charset_mode,
   input  mid_item_type mid_item,
   input  logic         mid_empty,
   output logic         mid_pop,
   output rsp_item_type rsp_item,
   output logic         rsp_push,
   input  logic         rsp_full
);

   localparam int CW = $clog2(BUFFER_BYTES);

   logic [2:0]    pend_ff, pend_in;
   logic [CW-1:0] ocount_ff, ocount_in;
   logic          stopped_ff, stopped_in;
   logic [1:0]    err_ff, err_in;
   logic          second_ff, second_in;
   logic          utf8_mode;

   // {valid, continuation bytes owed}
   function automatic logic [3:0] utf8_lead(input logic [7:0] b);
      logic [3:0] r;
      r = '0;
      priority if (!b[7]) r = {1'b1, 3'd0};
      else if (!b[6]) r = {1'b0, 3'd0};
      else if (!b[5]) r = {1'b1, 3'd1};
      else if (!b[4]) r = {1'b1, 3'd2};
      else if (!b[3]) r = {1'b1, 3'd3};
      else if (!b[2]) r = {1'b1, 3'd4};
      else if (!b[1]) r = {1'b1, 3'd5};
      else r = {1'b0, 3'd0};
      return r;
   endfunction

   assign utf8_mode = (charset_mode != CS_ASCII) && (charset_mode != CS_LATIN1);

   always_comb begin
      logic [7:0] b;
      logic [3:0] lead;
      logic       put_req;
      logic [7:0] put_byte;
      logic       fail_req;
      logic [1:0] err_fin;

      pend_in    = pend_ff;
      ocount_in  = ocount_ff;
      stopped_in = stopped_ff;
      err_in     = err_ff;
      second_in  = second_ff;
      mid_pop    = 1'b0;
      rsp_push   = 1'b0;
      rsp_item   = '{out_byte: 8'd0, is_final: 1'b0, status: ST_OK, out_length: 8'd0};
      b          = mid_item.data;
      lead       = utf8_lead(b);
      put_req    = 1'b0;
      put_byte   = b;
      fail_req   = 1'b0;
      err_fin    = err_ff;

      if (!mid_empty && !rsp_full) begin
         unique case (mid_item.kind)
            EV_FAIL: begin
               err_in     = mid_item.code;
               stopped_in = 1'b1;
               mid_pop    = 1'b1;
            end
            EV_END: begin
               if (!stopped_ff && utf8_mode && pend_ff != 3'd0 && err_ff == ST_OK) begin
                  err_fin = ST_INVALID;
               end
               rsp_push   = 1'b1;
               rsp_item   = '{out_byte: 8'd0, is_final: 1'b1, status: err_fin,
                              out_length: (err_fin == ST_OK) ? 8'(ocount_ff) : 8'd0};
               mid_pop    = 1'b1;
               pend_in    = 3'd0;
               ocount_in  = '0;
               stopped_in = 1'b0;
               err_in     = ST_OK;
               second_in  = 1'b0;
            end
            EV_BYTE: begin
               if (stopped_ff) begin
                  second_in = 1'b0;
                  mid_pop   = 1'b1;
               end else if (b == 8'h00) begin
                  if (utf8_mode && pend_ff != 3'd0) begin
                     fail_req = 1'b1;
                  end else begin
                     stopped_in = 1'b1;
                  end
                  mid_pop = 1'b1;
               end else if (charset_mode == CS_ASCII) begin
                  fail_req = b[7];
                  put_req  = !b[7];
                  mid_pop  = 1'b1;
               end else if (charset_mode == CS_LATIN1) begin
                  put_req = 1'b1;
                  if (!b[7]) begin
                     mid_pop = 1'b1;
                  end else if (!second_ff) begin
                     put_byte  = {6'b110000, b[7:6]};
                     second_in = 1'b1;
                  end else begin
                     put_byte  = {2'b10, b[5:0]};
                     second_in = 1'b0;
                     mid_pop   = 1'b1;
                  end
               end else if (pend_ff != 3'd0) begin
                  mid_pop = 1'b1;
                  if (b[7:6] != 2'b10) begin
                     fail_req = 1'b1;
                  end else begin
                     pend_in = pend_ff - 3'd1;
                     put_req = 1'b1;
                  end
               end else begin
                  mid_pop = 1'b1;
                  if (!lead[3]) begin
                     fail_req = 1'b1;
                  end else begin
                     pend_in = lead[2:0];
                     put_req = 1'b1;
                  end
               end
            end
            default: begin
               mid_pop = 1'b1;
            end
         endcase

         if (fail_req) begin
            if (err_ff == ST_OK) begin
               err_in = ST_INVALID;
            end
            stopped_in = 1'b1;
         end else if (put_req) begin
            if (ocount_ff == CW'(BUFFER_BYTES - 1)) begin
               if (err_ff == ST_OK) begin
                  err_in = ST_CAPACITY;
               end
               stopped_in = 1'b1;
            end else begin
               rsp_push  = 1'b1;
               rsp_item  = '{out_byte: put_byte, is_final: 1'b0, status: ST_OK,
                             out_length: 8'd0};
               ocount_in = ocount_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 3'd0;
         ocount_ff  <= '0;
         stopped_ff <= 1'b0;
         err_ff     <= ST_OK;
         second_ff  <= 1'b0;
      end else begin
         pend_ff    <= pend_in;
         ocount_ff  <= ocount_in;
         stopped_ff <= stopped_in;
         err_ff     <= err_in;
         second_ff  <= second_in;
      end
   end

endmodule

FILE: hw/rtl/encoded_word_text_decoder_core.sv
// ----------------------------------------------------------------------------
// Encoded-word text decoder core
// Decodes the encoded text of one encoded word, base64 or Q, and checks or
// converts the bytes for US-ASCII, UTF-8 or Latin-1 to UTF-8. Characters
// enter through push/full and UTF-8 bytes leave through empty/pop, followed
// by one final item with the length or an error status. A character that
// yields bytes holds the input while the front end queues them, up to three
// on a full base64 group. The back end issues one output byte per cycle
// while the result queue has room, and two output bytes for a Latin-1 byte
// at or above 0x80. A four-entry event queue and a two-entry result queue
// decouple the stages; first output passes through the front end's pending
// register, the event queue and the result queue.
// ----------------------------------------------------------------------------
`include "encoded_word_text_decoder_core_defines.svh"

module encoded_word_text_decoder_core import ewd_pkg::*; #(
   parameter int BUFFER_BYTES = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_text_byte,
   input  logic       req_text_end,
   input  logic       push,
   output logic       full,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_final,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_out_length,
   output logic       empty,
   input  logic       pop,
   input  logic       csr_write_en,
   input  logic       csr_index,
   input  logic [1:0] csr_write_data
);

   logic         enc_ff, enc_in;
   logic [1:0]   cs_ff, cs_in;
   logic         in_ready;
   mid_item_type front_item, back_item;
   logic         mid_push, mid_full, mid_pop, mid_empty;
   rsp_item_type back_rsp, out_rsp;
   logic         rsp_push, rsp_full;

   always_comb begin
      enc_in = enc_ff;
      cs_in  = cs_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ENCODING: enc_in = csr_write_data[0];
            CSR_CHARSET:  cs_in  = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enc_ff <= ENC_B64;
         cs_ff  <= CS_UTF8;
      end else begin
         enc_ff <= enc_in;
         cs_ff  <= cs_in;
      end
   end

   assign full = !in_ready;

   ewd_front #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .encoding_mode(enc_ff),
      .in_valid     (push),
      .in_byte      (req_text_byte),
      .in_end       (req_text_end),
      .in_ready     (in_ready),
      .mid_item     (front_item),
      .mid_push     (mid_push),
      .mid_full     (mid_full)
   );

   ewd_fifo #(
      .WIDTH($bits(mid_item_type)),
      .DEPTH(MID_DEPTH)
   ) u_mid_fifo (
      .clock(clock),
      .reset(reset),
      .push (mid_push),
      .wdata(front_item),
      .full (mid_full),
      .pop  (mid_pop),
      .rdata(back_item),
      .empty(mid_empty)
   );

   ewd_back #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .charset_mode(cs_ff),
      .mid_item    (back_item),
      .mid_empty   (mid_empty),
      .mid_pop     (mid_pop),
      .rsp_item    (back_rsp),
      .rsp_push    (rsp_push),
      .rsp_full    (rsp_full)
   );

   ewd_fifo #(
      .WIDTH($bits(rsp_item_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock(clock),
      .reset(reset),
      .push (rsp_push),
      .wdata(back_rsp),
      .full (rsp_full),
      .pop  (pop),
      .rdata(out_rsp),
      .empty(empty)
   );

   assign rsp_out_byte   = out_rsp.out_byte;
   assign rsp_is_final   = out_rsp.is_final;
   assign rsp_status     = out_rsp.status;
   assign rsp_out_length = out_rsp.out_length;

   // an error status never carries a length
   `EWD_ASSERT_IMPLIES(a_err_no_length, clock, reset, !empty && rsp_is_final && rsp_status != ST_OK, rsp_out_length == 8'd0, "final error item with nonzero length")
   // byte transfers carry no status and no length
   `EWD_ASSERT_IMPLIES(a_byte_clean, clock, reset, !empty && !rsp_is_final, rsp_status == ST_OK && rsp_out_length == 8'd0, "byte item with status or length set")
   // reset drains both sides
   `EWD_ASSERT_NEXT(a_reset_idle, clock, reset, empty && !full, "queues not idle after reset")

endmodule

FILE: tb/sv/tb_encoded_word_text_decoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Encoded-word text decoder core testbench
// Feeds encoded-text characters through the push/full queue port. Each
// transfer is scored by an in-bench decoder model, which queues the UTF-8
// bytes and the closing status that the word should produce. Results popped
// from the empty/pop port are compared field by field against that queue.
// The run starts with directed words and then moves to random base64 and Q
// words, both well formed and broken, under every encoding and charset code.
// It closes with a long Latin-1 word that runs past the 255-byte output
// limit. One random phase runs with no gaps while the reader holds off for
// a long stretch.
// ----------------------------------------------------------------------------
module tb_encoded_word_text_decoder_core;
   import ewd_pkg::*;

   localparam int CLK_PERIOD   = 4;
   localparam int RESET_CYCLES = 7;
   localparam int BUFFER_BYTES = 256;
   localparam int DRAIN_CYCLES = 16;
   localparam int IDLE_PERCENT = 19;
   localparam int HOLD_CYCLES  = 250;
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 20;

   localparam logic [1:0] CS_SPARE = 2'd3;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       text_end;
   } text_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic [7:0] req_text_byte = 8'h00;
   logic       req_text_end = 1'b0;
   logic       push = 1'b0;
   logic       full;
   logic [7:0] rsp_out_byte;
   logic       rsp_is_final;
   logic [1:0] rsp_status;
   logic [7:0] rsp_out_length;
   logic       empty;
   logic       pop = 1'b0;
   logic       csr_write_en = 1'b0;
   logic       csr_index = CSR_ENCODING;
   logic [1:0] csr_write_data = 2'd0;

   // decoder model state
   logic        cfg_encoding = ENC_B64;
   logic [1:0]  cfg_charset = CS_UTF8;
   int          grp_pos, pad_cnt, q_phase, utf8_owed, dec_cnt, out_cnt;
   logic [23:0] grp_bits;
   logic [3:0]  hi_nibble;
   bit          out_halted, dec_failed;
   logic [1:0]  err_code;

   text_item_type text_items[$];
   rsp_item_type  expected_rsp[$];
   rsp_item_type  next_expected;
   logic [7:0]    plain_bytes[$];
   logic [7:0]    enc_chars[$];

   bit gaps_on = 1'b1;
   bit hold_armed = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int stall_cycles = 0;

   int mismatch_count = 0;
   int results_checked = 0;
   int items_total = 0;
   int words_closed = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   logic       enc_order [2] = '{ENC_B64, ENC_Q};
   logic [1:0] charset_order [4] = '{CS_UTF8, CS_LATIN1, CS_ASCII, CS_SPARE};
   int         ci, ei, phase_no, phase_start;

   encoded_word_text_decoder_core #(.BUFFER_BYTES(BUFFER_BYTES)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_text_byte  (req_text_byte),
      .req_text_end   (req_text_end),
      .push           (push),
      .full           (full),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_final   (rsp_is_final),
      .rsp_status     (rsp_status),
      .rsp_out_length (rsp_out_length),
      .empty          (empty),
      .pop            (pop),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // decoder model
   // ------------------------------------------------------------------
   function automatic void clear_word_state();
      grp_pos = 0;
      grp_bits = '0;
      pad_cnt = 0;
      q_phase = 0;
      hi_nibble = '0;
      utf8_owed = 0;
      dec_cnt = 0;
      out_cnt = 0;
      out_halted = 1'b0;
      err_code = ST_OK;
      dec_failed = 1'b0;
   endfunction

   function automatic void charset_fail(logic [1:0] code);
      if (err_code == ST_OK) err_code = code;
      out_halted = 1'b1;
   endfunction

   function automatic void decode_fail(logic [1:0] code);
      dec_failed = 1'b1;
      err_code = code;
      out_halted = 1'b1;
   endfunction

   function automatic void emit_utf8(logic [7:0] b);
      rsp_item_type item;
      if (out_halted) return;
      if (out_cnt >= BUFFER_BYTES - 1) begin
         charset_fail(ST_CAPACITY);
         return;
      end
      item.out_byte = b;
      item.is_final = 1'b0;
      item.status = ST_OK;
      item.out_length = 8'h00;
      expected_rsp.push_back(item);
      out_cnt++;
   endfunction

   // a zero byte closes the output
   function automatic void convert_byte(logic [7:0] b);
      int owed;
      if (out_halted) return;
      if (b == 8'h00) begin
         if (cfg_charset != CS_ASCII && cfg_charset != CS_LATIN1 && utf8_owed != 0)
            charset_fail(ST_INVALID);
         else
            out_halted = 1'b1;
         return;
      end
      if (cfg_charset == CS_ASCII) begin
         if (b[7]) charset_fail(ST_INVALID);
         else emit_utf8(b);
      end else if (cfg_charset == CS_LATIN1) begin
         if (!b[7]) begin
            emit_utf8(b);
         end else begin
            emit_utf8({6'b110000, b[7:6]});
            emit_utf8({2'b10, b[5:0]});
         end
      end else if (utf8_owed != 0) begin
         if (b[7:6] != 2'b10) begin
            charset_fail(ST_INVALID);
         end else begin
            utf8_owed--;
            emit_utf8(b);
         end
      end else begin
         casez (b)
            8'b0???????: owed = 0;
            8'b10??????: owed = -1;
            8'b110?????: owed = 1;
            8'b1110????: owed = 2;
            8'b11110???: owed = 3;
            8'b111110??: owed = 4;
            8'b1111110?: owed = 5;
            default:     owed = -1;
         endcase
         if (owed < 0) begin
            charset_fail(ST_INVALID);
         end else begin
            utf8_owed = owed;
            emit_utf8(b);
         end
      end
   endfunction

   function automatic void decoded_byte(logic [7:0] b);
      if (dec_failed) return;
      if (dec_cnt >= BUFFER_BYTES - 1) begin
         decode_fail(ST_CAPACITY);
         return;
      end
      dec_cnt++;
      convert_byte(b);
   endfunction

   function automatic int b64_digit(logic [7:0] c);
      if (c >= "A" && c <= "Z") return c - "A";
      if (c >= "a" && c <= "z") return c - "a" + 26;
      if (c >= "0" && c <= "9") return c - "0" + 52;
      if (c == "+") return 62;
      if (c == "/") return 63;
      return -1;
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return -1;
   endfunction

   function automatic void take_b64_char(logic [7:0] c);
      int v;
      if (pad_cnt != 0 && grp_pos == 0) begin
         decode_fail(ST_MALFORMED);
         return;
      end
      if (grp_pos >= 2 && c == CH_EQUALS) begin
         pad_cnt++;
      end else begin
         v = b64_digit(c);
         if (v < 0 || pad_cnt != 0) begin
            decode_fail(ST_MALFORMED);
            return;
         end
         grp_bits = grp_bits | (24'(v) << (18 - 6 * grp_pos));
      end
      if (grp_pos < 3) begin
         grp_pos++;
         return;
      end
      grp_pos = 0;
      decoded_byte(grp_bits[23:16]);
      if (pad_cnt < 2) decoded_byte(grp_bits[15:8]);
      if (pad_cnt < 1) decoded_byte(grp_bits[7:0]);
      grp_bits = '0;
   endfunction

   function automatic void take_q_char(logic [7:0] c);
      int v;
      if (q_phase == 0) begin
         if (c == CH_UNDERSCORE) decoded_byte(CH_SPACE);
         else if (c == CH_EQUALS) q_phase = 1;
         else decoded_byte(c);
         return;
      end
      v = hex_digit(c);
      if (v < 0) begin
         decode_fail(ST_MALFORMED);
         return;
      end
      if (q_phase == 1) begin
         hi_nibble = v[3:0];
         q_phase = 2;
         return;
      end
      q_phase = 0;
      decoded_byte({hi_nibble, v[3:0]});
   endfunction

   function automatic void predict_text_item(logic [7:0] c, logic end_flag);
      rsp_item_type fin;
      if (!end_flag && c != 8'h00) begin
         if (!dec_failed) begin
            if (cfg_encoding == ENC_B64) take_b64_char(c);
            else take_q_char(c);
         end
         return;
      end
      if (!dec_failed && (cfg_encoding == ENC_B64 ? grp_pos != 0 : q_phase != 0))
         decode_fail(ST_MALFORMED);
      convert_byte(8'h00);
      fin.out_byte = 8'h00;
      fin.is_final = 1'b1;
      fin.status = err_code;
      fin.out_length = (err_code == ST_OK) ? 8'(out_cnt) : 8'h00;
      expected_rsp.push_back(fin);
      status_seen[err_code]++;
      words_closed++;
      clear_word_state();
   endfunction

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   function automatic logic [7:0] b64_symbol(logic [5:0] v);
      if (v < 26) return "A" + v;
      if (v < 52) return "a" + (v - 26);
      if (v < 62) return "0" + (v - 52);
      if (v == 62) return "+";
      return "/";
   endfunction

   function automatic logic [7:0] hex_symbol(logic [3:0] n, bit upper);
      if (n < 4'd10) return "0" + {4'h0, n};
      return (upper ? "A" : "a") + {4'h0, n} - 8'd10;
   endfunction

   task automatic add_text_item(logic [7:0] b, logic e);
      text_item_type item;
      item.text_byte = b;
      item.text_end = e;
      text_items.push_back(item);
      items_total++;
   endtask

   task automatic add_string(string s);
      int k;
      for (k = 0; k < s.len(); k++) add_text_item(s[k], 1'b0);
   endtask

   task automatic add_word_end();
      if ($urandom_range(2) == 0) add_text_item(8'h00, 1'b0);
      else add_text_item(8'($urandom), 1'b1);
   endtask

   task automatic make_payload(int n_chars, bit clean);
      int k, n, kind;
      logic [7:0] lead;
      plain_bytes.delete();
      for (k = 0; k < n_chars; k++) begin
         kind = $urandom_range(99);
         if (clean || kind < 45) begin
            plain_bytes.push_back(8'($urandom_range(8'h7e, 8'h20)));
         end else if (kind < 82) begin
            n = $urandom_range(5, 1);
            case (n)
               1:       lead = {3'b110, 5'($urandom)};
               2:       lead = {4'b1110, 4'($urandom)};
               3:       lead = {5'b11110, 3'($urandom)};
               4:       lead = {6'b111110, 2'($urandom)};
               default: lead = {7'b1111110, 1'($urandom)};
            endcase
            plain_bytes.push_back(lead);
            // cut the tail short now and then
            if (kind >= 75) n = $urandom_range(n - 1);
            repeat (n) plain_bytes.push_back({2'b10, 6'($urandom)});
         end else if (kind < 97) begin
            plain_bytes.push_back(8'($urandom));
         end else begin
            plain_bytes.push_back(8'h00);
         end
      end
   endtask

   task automatic encode_b64();
      int k, n;
      logic [23:0] w;
      enc_chars.delete();
      n = plain_bytes.size();
      for (k = 0; k < n; k += 3) begin
         w = {plain_bytes[k], (k + 1 < n) ? plain_bytes[k + 1] : 8'h00,
              (k + 2 < n) ? plain_bytes[k + 2] : 8'h00};
         enc_chars.push_back(b64_symbol(w[23:18]));
         enc_chars.push_back(b64_symbol(w[17:12]));
         enc_chars.push_back((k + 1 < n) ? b64_symbol(w[11:6]) : CH_EQUALS);
         enc_chars.push_back((k + 2 < n) ? b64_symbol(w[5:0]) : CH_EQUALS);
      end
   endtask

   task automatic encode_q();
      int k;
      bit upper;
      logic [7:0] b;
      enc_chars.delete();
      for (k = 0; k < plain_bytes.size(); k++) begin
         b = plain_bytes[k];
         if (b == CH_SPACE && $urandom_range(1)) begin
            enc_chars.push_back(CH_UNDERSCORE);
         end else if (b != 8'h00 && b != CH_EQUALS && b != CH_UNDERSCORE &&
                      $urandom_range(3) != 0) begin
            enc_chars.push_back(b);
         end else begin
            upper = $urandom_range(1);
            enc_chars.push_back(CH_EQUALS);
            enc_chars.push_back(hex_symbol(b[7:4], upper));
            enc_chars.push_back(hex_symbol(b[3:0], upper));
         end
      end
   endtask

   task automatic push_word(bit broken);
      int k, pos;
      if (broken) begin
         pos = $urandom_range(enc_chars.size());
         case ($urandom_range(3))
            0: begin
               if (enc_chars.size() != 0) enc_chars[pos % enc_chars.size()] = 8'($urandom);
            end
            1: begin
               if (cfg_encoding == ENC_B64) begin
                  if (enc_chars.size() != 0) void'(enc_chars.pop_back());
               end else begin
                  enc_chars.push_back(CH_EQUALS);
                  if ($urandom_range(1)) enc_chars.push_back(hex_symbol(4'($urandom), 1'b1));
               end
            end
            2: begin
               if (cfg_encoding == ENC_B64) begin
                  enc_chars.push_back(b64_symbol(6'($urandom)));
               end else begin
                  enc_chars.push_back(CH_EQUALS);
                  enc_chars.push_back(8'($urandom_range(8'h7e, 8'h67)));
               end
            end
            default: enc_chars.insert(pos, CH_EQUALS);
         endcase
      end
      for (k = 0; k < enc_chars.size(); k++) add_text_item(enc_chars[k], 1'b0);
      add_word_end();
   endtask

   task automatic add_random_word();
      int len, k;
      bit clean;
      len = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6);
      if ($urandom_range(19) == 0) begin
         enc_chars.delete();
         for (k = 0; k < len; k++) enc_chars.push_back(8'($urandom));
         push_word(1'b0);
         return;
      end
      clean = $urandom_range(99) < ((cfg_charset == CS_ASCII) ? 70 : 20);
      make_payload(len, clean);
      if (cfg_encoding == ENC_B64) encode_b64();
      else encode_q();
      push_word($urandom_range(99) < 20);
   endtask

   task automatic add_long_word(int n, logic [7:0] lo, logic [7:0] hi);
      repeat (n) add_text_item(8'($urandom_range(hi, lo)), 1'b0);
      add_word_end();
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (text_items.size() != 0 || expected_rsp.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(logic enc, logic [1:0] cs);
      wait_drained();
      csr_write_en <= 1'b1;
      csr_index <= CSR_ENCODING;
      csr_write_data <= {1'b0, enc};
      @(posedge clock);
      csr_index <= CSR_CHARSET;
      csr_write_data <= cs;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_encoding = enc;
      cfg_charset = cs;
      @(negedge clock);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      apply_config(ENC_B64, CS_UTF8);
      add_string("////");
      add_text_item(8'hff, 1'b1);
      add_string("AAA=");
      add_text_item(8'h00, 1'b0);
      apply_config(ENC_Q, CS_LATIN1);
      add_string("_=E9a");
      add_text_item(8'h00, 1'b1);
      add_string("=g");
      add_text_item(8'h00, 1'b0);
      add_string("=4");
      add_text_item(8'h3c, 1'b1);

      phase_no = 0;
      for (ci = 0; ci < 4; ci++) begin
         for (ei = 0; ei < 2; ei++) begin
            apply_config(enc_order[ei], charset_order[ci]);
            if (phase_no == 0) begin
               gaps_on = 1'b0;
               hold_armed = 1'b1;
            end else begin
               gaps_on = 1'b1;
            end
            phase_start = items_total;
            while (items_total - phase_start < PHASE_ITEMS) add_random_word();
            phase_no++;
         end
      end

      apply_config(ENC_Q, CS_LATIN1);
      add_long_word(BUFFER_BYTES / 2 + 2, 8'h80, 8'hff);

      wait_drained();
      $display("covered %0d text items in %0d words, base64 and Q, all four charset codes",
               items_total, words_closed);
      $display("checked %0d results; words ok %0d, malformed %0d, invalid %0d, capacity %0d",
               results_checked, status_seen[ST_OK], status_seen[ST_MALFORMED],
               status_seen[ST_INVALID], status_seen[ST_CAPACITY]);
      if (mismatch_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   // ------------------------------------------------------------------
   // driver, monitor, watchdog
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
         clear_word_state();
      end else begin
         if (push && !full) begin
            predict_text_item(req_text_byte, req_text_end);
            void'(text_items.pop_front());
         end
         // hold the offered item while the block is full
         if (!push || !full) begin
            if (text_items.size() != 0 && !(gaps_on && $urandom_range(99) < IDLE_PERCENT)) begin
               push <= 1'b1;
               req_text_byte <= text_items[0].text_byte;
               req_text_end <= text_items[0].text_end;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
      mismatch_count++;
      $display("[%0t] result %0d: %s is %0h, expected %0h",
               $time, results_checked, field, got, want);
   endtask

   task automatic check_field(string field, logic [7:0] got, logic [7:0] want);
      if (got !== want) report_mismatch(field, got, want);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            results_checked++;
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected transfer, out_byte", rsp_out_byte, 8'h00);
            end else begin
               next_expected = expected_rsp.pop_front();
               check_field("out_byte", rsp_out_byte, next_expected.out_byte);
               check_field("is_final", {7'b0, rsp_is_final}, {7'b0, next_expected.is_final});
               check_field("status", {6'b0, rsp_status}, {6'b0, next_expected.status});
               check_field("out_length", rsp_out_length, next_expected.out_length);
            end
         end
         if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= !(gaps_on && $urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
